// ===== src/mssq_pkg.sv =====
package mssq_pkg;

   // Input item kinds, carried on req_tuser
   typedef enum logic [1:0] {
      MODE_TICK = 2'd0,
      MODE_SET  = 2'd1,
      MODE_UP   = 2'd2,
      MODE_DOWN = 2'd3
   } mode_type;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_DUTY_MIN    = 2'd0;
   localparam logic [1:0] CSR_DUTY_MAX    = 2'd1;
   localparam logic [1:0] CSR_DUTY_STEP   = 2'd2;
   localparam logic [1:0] CSR_FRAME_TICKS = 2'd3;

   localparam int unsigned CSR_W = 16;

   localparam logic [CSR_W-1:0] DUTY_MIN_RESET    = 16'd1563;
   localparam logic [CSR_W-1:0] DUTY_MAX_RESET    = 16'd7813;
   localparam logic [CSR_W-1:0] DUTY_STEP_RESET   = 16'd50;
   localparam logic [CSR_W-1:0] FRAME_TICKS_RESET = 16'd62500;
   localparam logic [CSR_W-1:0] DUTY_RESET        = 16'd4688;

   typedef struct packed {
      logic [CSR_W-1:0] duty_min;
      logic [CSR_W-1:0] duty_max;
      logic [CSR_W-1:0] duty_step;
      logic [CSR_W-1:0] frame_ticks;
   } cfg_type;

   // Duty command presented to the duty table
   typedef struct packed {
      logic             fire;
      mode_type         mode;
      logic [2:0]       channel;
      logic [CSR_W-1:0] value;
   } cmd_type;

endpackage

// ===== src/mssq_duty_table.sv =====
module mssq_duty_table import mssq_pkg::*; #(
   parameter int CHANNELS  = 5,
   parameter int TICK_BITS = 16,
   localparam int PH_W     = $clog2(CHANNELS + 1),
   localparam int W        = (TICK_BITS > 16) ? TICK_BITS : 16,
   localparam int SW       = W + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   input  cfg_type              cfg,
   input  logic [PH_W-1:0]      phase_index,
   output logic [TICK_BITS-1:0] phase_duty,
   output logic [CSR_W-1:0]     duty_now
);

   logic [TICK_BITS-1:0] duty_ff [CHANNELS];
   logic [TICK_BITS-1:0] duty_in [CHANNELS];
   logic [TICK_BITS-1:0] cur;
   logic [TICK_BITS-1:0] nd;
   logic [SW-1:0]        sum_up;
   logic [W-1:0]         diff_dn;
   logic                 ch_ok;

   // one-hot lane selection for the addressed channel and the phase channel
   always_comb begin
      cur        = '0;
      phase_duty = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (32'(cmd.channel) == i) cur = cur | duty_ff[i];
         if (phase_index == PH_W'(i)) phase_duty = phase_duty | duty_ff[i];
      end
   end

   assign ch_ok   = 32'(cmd.channel) < CHANNELS;
   assign sum_up  = SW'(cur) + SW'(cfg.duty_step);
   assign diff_dn = W'(cur) - W'(cfg.duty_step);

   always_comb begin
      case (cmd.mode)
         MODE_SET: begin
            if (cmd.value >= cfg.duty_min && cmd.value <= cfg.duty_max) begin
               nd = TICK_BITS'(cmd.value);
            end else begin
               nd = cur;
            end
         end
         MODE_UP: begin
            nd = (sum_up > SW'(cfg.duty_max)) ? TICK_BITS'(cfg.duty_max) : TICK_BITS'(sum_up);
         end
         MODE_DOWN: begin
            // clamp tests the stepped result, also catches underflow
            if (W'(cur) >= W'(cfg.duty_step) && diff_dn >= W'(cfg.duty_min)) begin
               nd = TICK_BITS'(diff_dn);
            end else begin
               nd = TICK_BITS'(cfg.duty_min);
            end
         end
         default: nd = cur;
      endcase
   end

   assign duty_now = ch_ok ? CSR_W'(nd) : '0;

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         duty_in[i] = (cmd.fire && ch_ok && 32'(cmd.channel) == i) ? nd : duty_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CHANNELS; i++) begin
         if (reset) begin
            duty_ff[i] <= TICK_BITS'(DUTY_RESET);
         end else begin
            duty_ff[i] <= duty_in[i];
         end
      end
   end

endmodule

// ===== src/mssq_phase_seq.sv =====
module mssq_phase_seq import mssq_pkg::*; #(
   parameter int CHANNELS  = 5,
   parameter int TICK_BITS = 16,
   localparam int PH_W     = $clog2(CHANNELS + 1),
   localparam int CNT_W    = (TICK_BITS > 16) ? TICK_BITS : 16,
   localparam int SUM_RAW  = TICK_BITS + $clog2(CHANNELS),
   localparam int SUM_W    = (SUM_RAW > 32) ? 32 : SUM_RAW,
   localparam int CMP_W    = (SUM_W > 16) ? SUM_W : 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tick,
   input  logic [CSR_W-1:0]     frame_ticks,
   input  logic [TICK_BITS-1:0] phase_duty,
   output logic [PH_W-1:0]      phase_index,
   output logic [CHANNELS-1:0]  tick_lines,
   output logic [CHANNELS-1:0]  held_lines,
   output logic                 frame_start
);

   logic [PH_W-1:0]  phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] len;
   logic [CNT_W-1:0] count_eff;
   logic [SUM_W-1:0] sum_base;
   logic             in_pulse;
   logic             idle_cnt;

   assign idle_cnt    = (count_ff == '0);
   assign in_pulse    = 32'(phase_ff) < CHANNELS;
   assign frame_start = idle_cnt && (phase_ff == '0);
   assign sum_base    = frame_start ? '0 : sum_ff;

   // length of the phase that starts on this tick
   always_comb begin
      if (in_pulse) begin
         len = (phase_duty == '0) ? CNT_W'(1) : CNT_W'(phase_duty);
      end else if (CMP_W'(sum_ff) < CMP_W'(frame_ticks)) begin
         len = CNT_W'(frame_ticks - CSR_W'(sum_ff));
      end else begin
         len = CNT_W'(1);
      end
   end

   assign count_eff = idle_cnt ? len : count_ff;

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      phase_in = phase_ff;
      if (tick) begin
         count_in = count_eff - CNT_W'(1);
         if (idle_cnt && in_pulse) sum_in = sum_base + SUM_W'(len);
         if (count_in == '0) begin
            phase_in = in_pulse ? phase_ff + PH_W'(1) : '0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         tick_lines[i] = (phase_ff == PH_W'(i));
         held_lines[i] = (phase_ff == PH_W'(i)) && !idle_cnt;
      end
   end

   assign phase_index = phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

// ===== src/multiplexed_servo_pulse_sequencer.sv =====
// Multiplexed servo pulse sequencer. Drives CHANNELS servo lines one after
// another inside a frame of frame_ticks ticks: phase c holds line c high
// for the duty of channel c latched as the phase begins (zero duty still
// gives one tick), then a gap phase keeps all lines low for the rest of the
// frame, at least one tick. Each req transfer is one item: a timer tick
// (tuser mode 0) or a duty command on a channel (set within
// [duty_min, duty_max], step up or down by duty_step with clamping). Each
// item gives exactly one rsp transfer with the line state, the phase, a
// frame start flag and, for commands, the stored duty of the addressed
// channel (0 for ticks and for channels out of range). From req to rsp an
// item goes through an input register, then one pass through the duty
// table and the phase counter into the output register. One item is taken
// every cycle while rsp_tready is high. The user must write registers through
// csr_we/csr_index/csr_wdata only while no item is in flight; nothing enforces it.
module multiplexed_servo_pulse_sequencer import mssq_pkg::*; #(
   parameter int CHANNELS  = 5,
   parameter int TICK_BITS = 16,
   localparam int PH_W     = $clog2(CHANNELS + 1),
   localparam int REQ_W    = ((3 + CSR_W + 7) / 8) * 8,
   localparam int RSP_RAW  = CHANNELS + PH_W + CSR_W,
   localparam int RSP_W    = ((RSP_RAW + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // request stream
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // channel[2:0], value[18:3], zero pad
   input  logic [1:0]       req_tuser,   // mode
   // result stream
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // pulse_lines, phase, duty_now, zero pad
   output logic             rsp_tuser,   // frame_start
   // register writes
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   // input register
   logic             in_valid_ff;
   mode_type         in_mode_ff;
   logic [2:0]       in_channel_ff;
   logic [CSR_W-1:0] in_value_ff;

   // output register
   logic                rsp_valid_ff;
   logic [CHANNELS-1:0] out_lines_ff;
   logic [PH_W-1:0]     out_phase_ff;
   logic [CSR_W-1:0]    out_duty_ff;
   logic                out_start_ff;

   cfg_type cfg_ff;

   logic                 advance;
   logic                 is_tick;
   cmd_type              cmd;
   logic [TICK_BITS-1:0] phase_duty;
   logic [CSR_W-1:0]     duty_now;
   logic [PH_W-1:0]      phase_index;
   logic [CHANNELS-1:0]  tick_lines;
   logic [CHANNELS-1:0]  held_lines;
   logic                 frame_start;

   // the input stage moves on when the output register is free or drains now
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign is_tick    = (in_mode_ff == MODE_TICK);

   assign cmd.fire    = advance && !is_tick;
   assign cmd.mode    = in_mode_ff;
   assign cmd.channel = in_channel_ff;
   assign cmd.value   = in_value_ff;

   mssq_duty_table #(
      .CHANNELS  (CHANNELS),
      .TICK_BITS (TICK_BITS)
   ) u_duty (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg_ff),
      .phase_index (phase_index),
      .phase_duty  (phase_duty),
      .duty_now    (duty_now)
   );

   mssq_phase_seq #(
      .CHANNELS  (CHANNELS),
      .TICK_BITS (TICK_BITS)
   ) u_phase (
      .clock       (clock),
      .reset       (reset),
      .tick        (advance && is_tick),
      .frame_ticks (cfg_ff.frame_ticks),
      .phase_duty  (phase_duty),
      .phase_index (phase_index),
      .tick_lines  (tick_lines),
      .held_lines  (held_lines),
      .frame_start (frame_start)
   );

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duty_min    <= DUTY_MIN_RESET;
         cfg_ff.duty_max    <= DUTY_MAX_RESET;
         cfg_ff.duty_step   <= DUTY_STEP_RESET;
         cfg_ff.frame_ticks <= FRAME_TICKS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DUTY_MIN:    cfg_ff.duty_min    <= csr_wdata;
            CSR_DUTY_MAX:    cfg_ff.duty_max    <= csr_wdata;
            CSR_DUTY_STEP:   cfg_ff.duty_step   <= csr_wdata;
            CSR_FRAME_TICKS: cfg_ff.frame_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_mode_ff    <= mode_type'(req_tuser);
         in_channel_ff <= req_tdata[2:0];
         in_value_ff   <= req_tdata[3 +: CSR_W];
      end
   end

   // output register; a tick reports the line of its own phase
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_lines_ff <= is_tick ? tick_lines : held_lines;
         out_phase_ff <= phase_index;
         out_duty_ff  <= is_tick ? '0 : duty_now;
         out_start_ff <= is_tick && frame_start;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({out_duty_ff, out_phase_ff, out_lines_ff});
   assign rsp_tuser  = out_start_ff;

endmodule
